@@ hdl/ott_pkg.sv @@
// ----------------------------------------------------------------------------
// ott_pkg: shared types and constants of the object track table
// Register indexes, codes, widths, the front-to-back request struct and the result struct.
// ----------------------------------------------------------------------------
package ott_pkg;

	localparam int TableDepth = 16;
	localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int CntW = $clog2(TableDepth + 1);

	localparam logic [2:0] RegMinRadius   = 3'd0;
	localparam logic [2:0] RegImageWidth  = 3'd1;
	localparam logic [2:0] RegImageHeight = 3'd2;
	localparam logic [2:0] RegMaxLost     = 3'd3;
	localparam logic [2:0] RegMinKnown    = 3'd4;

	localparam logic [1:0] KindStatus = 2'd0;
	localparam logic [1:0] KindObject = 2'd1;
	localparam logic [1:0] KindNone   = 2'd2;

	localparam logic [1:0] StOutside = 2'd0;
	localparam logic [1:0] StMatched = 2'd1;
	localparam logic [1:0] StNew     = 2'd2;
	localparam logic [1:0] StFull    = 2'd3;

	// classified request from front to back
	typedef struct packed {
		logic        eof;     // end of frame
		logic        in_area; // detection in accepted area
		logic [11:0] x;
		logic [11:0] y;
		logic [15:0] rad_sq;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [15:0] id;
		logic [11:0] x;
		logic [11:0] y;
		logic        last;
	} res_t;

endpackage

@@ hdl/object_track_table_core.sv @@
// ----------------------------------------------------------------------------
// object_track_table_core: nearest-neighbor object track table
// Tracks detected objects, matches by radius, evicts on timeout at frame end.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  s_axis  | in  | tvalid/tready  | tdata det, tuser cmd
//  m_axis  | out | tvalid/tready  | tdata result, tuser out_kind, tlast
//  cfg     | in  | cfg_valid/rdy  | cfg_index, cfg_data
// Steps: a detection in the area takes the back sequencer through IDLE, a scan
// of the slots up to a match, and DONE; one outside the area goes from IDLE to
// DONE. An end of frame passes IDLE, the slots in EOF with a HOLD per reported
// object after the first, EMIT and DONE.
// Reset clears the valid bits at once, no sweep.
// A stalled m_axis stalls the back sequencer; the front keeps taking requests
// until its register and the two-entry queue are full.
module object_track_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // det_x, det_row, det_radius, now_seconds
	input  logic        s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // det_status, obj_id, obj_x, obj_y
	output logic [1:0]  m_axis_tuser,   // out_kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import ott_pkg::*;

	logic [7:0]  min_radius_q, max_lost_q, min_known_q;
	logic [11:0] width_q, height_q;
	logic        f_valid, f_ready, q_valid, q_ready, r_valid;
	req_t        f_req, q_req;
	res_t        r;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_radius_q <= 8'd10;
			width_q      <= 12'd640;
			height_q     <= 12'd480;
			max_lost_q   <= 8'd1;
			min_known_q  <= 8'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegMinRadius:   min_radius_q <= cfg_data[7:0];
				RegImageWidth:  width_q      <= cfg_data;
				RegImageHeight: height_q     <= cfg_data;
				RegMaxLost:     max_lost_q   <= cfg_data[7:0];
				RegMinKnown:    min_known_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ott_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(s_axis_tuser), .in_x(s_axis_tdata[11:0]), .in_row(s_axis_tdata[23:12]),
		.in_rad(s_axis_tdata[31:24]), .in_now(s_axis_tdata[63:32]),
		.min_radius(min_radius_q), .image_width(width_q), .image_height(height_q),
		.req_valid(f_valid), .req_ready(f_ready), .req(f_req)
	);

	ott_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
	);

	ott_back u_back (
		.clk, .arst_n,
		.req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.max_lost_time(max_lost_q), .min_known_time(min_known_q),
		.res_valid(r_valid), .res_ready(m_axis_tready), .res(r)
	);

	assign m_axis_tvalid = r_valid;
	assign m_axis_tdata  = {6'd0, r.y, r.x, r.id, r.status};
	assign m_axis_tuser  = r.kind;
	assign m_axis_tlast  = r.last;

endmodule

@@ hdl/ott_front.sv @@
// ----------------------------------------------------------------------------
// ott_front: input stage
// Flips row to y, checks the accepted area, squares the radius.
// ----------------------------------------------------------------------------
module ott_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            in_cmd,
	input  logic [11:0]     in_x,
	input  logic [11:0]     in_row,
	input  logic [7:0]      in_rad,
	input  logic [31:0]     in_now,
	input  logic [7:0]      min_radius,
	input  logic [11:0]     image_width,
	input  logic [11:0]     image_height,
	output logic            req_valid,
	input  logic            req_ready,
	output ott_pkg::req_t   req
);
	import ott_pkg::*;

	logic        y_neg;
	logic [12:0] y_full;
	logic [12:0] lim_h, lim_w;
	req_t        req_q;
	logic        valid_q;

	assign y_full = {1'b0, image_height} - {1'b0, in_row};
	assign y_neg  = y_full[12];
	assign lim_h  = {1'b0, image_height} - {5'd0, min_radius};
	assign lim_w  = {1'b0, image_width} - {5'd0, min_radius};

	assign in_ready  = !valid_q || req_ready;
	assign req_valid = valid_q;
	assign req       = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_q.eof    <= in_cmd;
			req_q.x      <= in_x;
			req_q.y      <= y_neg ? 12'd0 : y_full[11:0];
			// lim_h/lim_w may wrap negative: compare as signed 13-bit
			req_q.in_area <= !y_neg && ($signed(y_full) < $signed(lim_h))
				&& ({1'b0, in_x} > {5'd0, min_radius})
				&& ($signed({1'b0, in_x}) < $signed(lim_w));
			req_q.rad_sq <= {8'd0, in_rad} * {8'd0, in_rad};
			req_q.now    <= in_now;
		end
	end

endmodule

@@ hdl/ott_fifo.sv @@
// ----------------------------------------------------------------------------
// ott_fifo: two-entry request queue between front and back
// ----------------------------------------------------------------------------
module ott_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  ott_pkg::req_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output ott_pkg::req_t rd_data
);
	import ott_pkg::*;

	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

@@ hdl/ott_back.sv @@
// ----------------------------------------------------------------------------
// ott_back: table sequencer
// Scans the entries one per cycle to match, allocate, evict and report; at frame end it pauses in HOLD per report.
// ----------------------------------------------------------------------------
module ott_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ott_pkg::req_t req,
	input  logic [7:0]    max_lost_time,
	input  logic [7:0]    min_known_time,
	output logic          res_valid,
	input  logic          res_ready,
	output ott_pkg::res_t res
);
	import ott_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DONE = 3'd2;
	localparam logic [2:0] S_EOF  = 3'd3;
	localparam logic [2:0] S_HOLD = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]      state_q;
	logic [IdxW-1:0] idx_q;
	logic [TableDepth-1:0] valid_q;
	logic [11:0]     ex_q [TableDepth];
	logic [11:0]     ey_q [TableDepth];
	logic [15:0]     eid_q [TableDepth];
	logic [31:0]     efs_q [TableDepth];
	logic [31:0]     els_q [TableDepth];
	logic [15:0]     next_id_q;
	logic            free_found_q;
	logic [IdxW-1:0] free_q;
	logic            any_q;
	res_t            pend_q;
	res_t            res_q;
	logic            out_q;

	logic signed [12:0] dx, dy;
	logic [25:0]     dx_sq, dy_sq, dist_sq;
	logic            hit, is_last, ok;
	logic [31:0]     lost, known;

	assign dx   = $signed({1'b0, ex_q[idx_q]}) - $signed({1'b0, req.x});
	assign dy   = $signed({1'b0, ey_q[idx_q]}) - $signed({1'b0, req.y});
	assign dx_sq = 26'(dx) * 26'(dx);
	assign dy_sq = 26'(dy) * 26'(dy);
	assign dist_sq = dx_sq + dy_sq;
	assign hit  = valid_q[idx_q] && (dist_sq < {10'd0, req.rad_sq});
	assign is_last = idx_q == IdxW'(TableDepth - 1);
	assign lost  = req.now - els_q[idx_q];
	assign known = els_q[idx_q] - efs_q[idx_q];
	assign ok = valid_q[idx_q] && (lost < {24'd0, max_lost_time})
		&& (known >= {24'd0, min_known_time});

	assign req_ready = state_q == S_DONE && !out_q;
	assign res_valid = out_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			next_id_q <= 16'd0;
			out_q     <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (out_q && res_ready) out_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					free_found_q <= 1'b0;
					any_q <= 1'b0;
					if (req_valid && !out_q) begin
						if (req.eof) begin
							state_q <= S_EOF;
						end else if (!req.in_area) begin
							res_q   <= '{KindStatus, StOutside, 16'd0, req.x, req.y, 1'b1};
							out_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (!valid_q[idx_q] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= idx_q;
					end
					if (hit) begin
						ex_q[idx_q]  <= req.x;
						ey_q[idx_q]  <= req.y;
						els_q[idx_q] <= req.now;
						res_q <= '{KindStatus, StMatched, eid_q[idx_q], req.x, req.y, 1'b1};
						out_q <= 1'b1;
						state_q <= S_DONE;
					end else if (is_last) begin
						if (free_found_q || !valid_q[idx_q]) begin
							ex_q[free_found_q ? free_q : idx_q]  <= req.x;
							ey_q[free_found_q ? free_q : idx_q]  <= req.y;
							eid_q[free_found_q ? free_q : idx_q] <= next_id_q;
							efs_q[free_found_q ? free_q : idx_q] <= req.now;
							els_q[free_found_q ? free_q : idx_q] <= req.now;
							valid_q[free_found_q ? free_q : idx_q] <= 1'b1;
							next_id_q <= next_id_q + 16'd1;
							res_q <= '{KindStatus, StNew, next_id_q, req.x, req.y, 1'b1};
						end else begin
							res_q <= '{KindStatus, StFull, 16'd0, req.x, req.y, 1'b1};
						end
						out_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + IdxW'(1);
					end
				end
				S_EOF: begin
					// evict stale; report known, one slot per step; the
					// candidate waits in pend_q until the next one is found
					if (valid_q[idx_q] && !(lost < {24'd0, max_lost_time}))
						valid_q[idx_q] <= 1'b0;
					if (ok) begin
						if (any_q) begin
							res_q <= pend_q;
							out_q <= 1'b1;
							state_q <= S_HOLD;
						end
						pend_q <= '{KindObject, StOutside, eid_q[idx_q], ex_q[idx_q],
							ey_q[idx_q], 1'b0};
						any_q <= 1'b1;
					end
					// HOLD moves on to the next slot, or to EMIT after the last, once the result is taken
					if (!(ok && any_q)) begin
						if (is_last) state_q <= S_EMIT;
						else idx_q <= idx_q + IdxW'(1);
					end
				end
				S_HOLD: begin
					if (!out_q || res_ready) begin
						if (is_last) begin
							state_q <= S_EMIT;
						end else begin
							idx_q <= idx_q + IdxW'(1);
							state_q <= S_EOF;
						end
					end
				end
				S_EMIT: begin
					if (!out_q || res_ready) begin
						if (any_q)
							res_q <= '{pend_q.kind, pend_q.status, pend_q.id,
								pend_q.x, pend_q.y, 1'b1};
						else
							res_q <= '{KindNone, StOutside, 16'd0, 12'd0, 12'd0, 1'b1};
						out_q <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_q) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/ott_checker.sv @@
// ----------------------------------------------------------------------------
// ott_checker: port-level checks of the object track table
// ----------------------------------------------------------------------------
module ott_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import ott_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("bad kind");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KindNone |-> m_axis_tlast && m_axis_tdata == '0)
		else $error("empty marker malformed");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KindStatus |-> m_axis_tlast)
		else $error("status not last");

endmodule

bind object_track_table_core ott_checker u_chk (.*);
